>>> src/aesctr_pkg.sv
// ----------------------------------------------------------------------------
// aesctr_pkg
// Shared types, constants and AES helper functions for the counter-mode
// keystream block.
// ----------------------------------------------------------------------------
package aesctr_pkg;

  localparam int CfgWidth = 64;
  localparam int CfgIdxWidth = 3;
  localparam int RoundWidth = 4;
  localparam int NumRounds = 14;

  // register indexes
  localparam logic [CfgIdxWidth-1:0] REG_KEY0 = 3'd0;
  localparam logic [CfgIdxWidth-1:0] REG_KEY1 = 3'd1;
  localparam logic [CfgIdxWidth-1:0] REG_KEY2 = 3'd2;
  localparam logic [CfgIdxWidth-1:0] REG_KEY3 = 3'd3;
  localparam logic [CfgIdxWidth-1:0] REG_NONCE = 3'd4;
  localparam logic [CfgIdxWidth-1:0] REG_IV = 3'd5;
  localparam logic [CfgIdxWidth-1:0] REG_CTR = 3'd6;

  localparam logic [31:0] CounterReset = 32'd1;
  localparam logic [7:0] ByteMask = 8'hff;

  // commands from controller to datapath
  typedef struct packed {
    logic take;
    logic start;
    logic round;
    logic fin;
    logic emit;
  } aesctr_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic ks_empty;
  } aesctr_sts_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // byte i of a 128-bit block, byte 0 in the top bits
  function automatic logic [7:0] blk_byte(input logic [127:0] s, input int i);
    blk_byte = s[127-8*i -: 8];
  endfunction

  // one cipher round without the key add; mix columns skipped on the final round
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic fin);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, x;
    logic [127:0] o;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*c+r] = SBOX[blk_byte(s, 4*((c+r)%4)+r)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c];
      a1 = t[4*c+1];
      a2 = t[4*c+2];
      a3 = t[4*c+3];
      x = a0 ^ a1 ^ a2 ^ a3;
      if (fin) begin
        o[127-32*c -: 32] = {a0, a1, a2, a3};
      end else begin
        o[127-32*c -: 32] = {a0 ^ x ^ xtime(a0 ^ a1), a1 ^ x ^ xtime(a1 ^ a2),
                             a2 ^ x ^ xtime(a2 ^ a3), a3 ^ x ^ xtime(a3 ^ a0)};
      end
    end
    aes_round = o;
  endfunction

  // slide the eight-word key window forward by four words
  function automatic logic [255:0] key_step(input logic [255:0] kw, input logic even,
                                            input logic [7:0] rc);
    logic [31:0] w7, f, n0, n1, n2, n3;
    w7 = kw[31:0];
    if (even) begin
      f = sub_word({w7[23:0], w7[31:24]}) ^ {rc, 24'h0};
    end else begin
      f = sub_word(w7);
    end
    n0 = kw[255:224] ^ f;
    n1 = kw[223:192] ^ n0;
    n2 = kw[191:160] ^ n1;
    n3 = kw[159:128] ^ n2;
    key_step = {kw[127:0], n0, n1, n2, n3};
  endfunction

endpackage

>>> src/aesctr_ctrl.sv
// ----------------------------------------------------------------------------
// aesctr_ctrl
// Controller: sequences request intake, the fourteen cipher rounds and the
// result hand-off.
// ----------------------------------------------------------------------------
module aesctr_ctrl
  import aesctr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  aesctr_sts_t sts,
  output aesctr_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [RoundWidth-1:0] rnd_r, rnd_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free = !out_valid_r || !out_stall;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    rnd_nxt = rnd_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (sts.ks_empty) begin
            cmd.start = 1'b1;
            rnd_nxt = RoundWidth'(1);
            state_nxt = ST_RUN;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_RUN: begin
        cmd.round = 1'b1;
        cmd.fin = (rnd_r == RoundWidth'(NumRounds));
        rnd_nxt = rnd_r + RoundWidth'(1);
        if (cmd.fin) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rnd_r <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> src/aesctr_dp.sv
// ----------------------------------------------------------------------------
// aesctr_dp
// Datapath: configuration registers, AES round unit with on-the-fly key
// schedule, keystream buffer and byte position.
// ----------------------------------------------------------------------------
module aesctr_dp
  import aesctr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0]    cfg_wdata,
  input  logic [7:0]             in_data,
  input  logic                   in_last,
  output logic [7:0]             out_data,
  input  aesctr_cmd_t            cmd,
  output aesctr_sts_t            sts
);

  logic [255:0] key_r;
  logic [31:0] nonce_r;
  logic [63:0] iv_r;
  logic [31:0] ctr_r;
  logic [4:0] pos_r;
  logic [127:0] ks_r;
  logic [127:0] st_r;
  logic [255:0] kw_r;
  logic [7:0] rc_r;
  logic even_r;
  logic [7:0] data_r;
  logic last_r;
  logic [7:0] out_r;
  logic [127:0] rnd_out;

  assign sts.ks_empty = pos_r[4];
  assign out_data = out_r;
  assign rnd_out = aes_round(st_r, cmd.fin) ^ kw_r[255:128];

  // configuration, counter and byte position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
      nonce_r <= '0;
      iv_r <= '0;
      ctr_r <= CounterReset;
      pos_r <= 5'd16;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY0: key_r[255:192] <= cfg_wdata;
          REG_KEY1: key_r[191:128] <= cfg_wdata;
          REG_KEY2: key_r[127:64] <= cfg_wdata;
          REG_KEY3: key_r[63:0] <= cfg_wdata;
          REG_NONCE: nonce_r <= cfg_wdata[31:0];
          REG_IV: iv_r <= cfg_wdata;
          REG_CTR: begin
            ctr_r <= cfg_wdata[31:0];
            pos_r <= 5'd16;
          end
          default: ;
        endcase
      end
      if (cmd.round && cmd.fin) begin
        ctr_r <= ctr_r + 32'd1;
        pos_r <= '0;
      end
      if (cmd.emit) begin
        pos_r <= last_r ? 5'd16 : pos_r + 5'd1;
      end
    end
  end

  // round unit, keystream and result byte
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      data_r <= in_data;
      last_r <= in_last;
    end
    if (cmd.start) begin
      st_r <= {nonce_r, iv_r, ctr_r} ^ key_r[255:128];
      kw_r <= key_step(key_r, 1'b1, 8'h01);
      rc_r <= 8'h02;
      even_r <= 1'b0;
    end else if (cmd.round) begin
      st_r <= rnd_out;
      kw_r <= key_step(kw_r, even_r, rc_r);
      if (even_r) begin
        rc_r <= xtime(rc_r);
      end
      even_r <= !even_r;
      if (cmd.fin) begin
        ks_r <= rnd_out;
      end
    end
    if (cmd.emit) begin
      out_r <= (data_r ^ ks_r[127 - 8*pos_r[3:0] -: 8]) & ByteMask;
    end
  end

endmodule

>>> src/aes256_ctr_keystream_xor.sv
// ----------------------------------------------------------------------------
// aes256_ctr_keystream_xor
// AES-256 counter-mode byte stream transform (nonce | iv | 32-bit counter).
// ----------------------------------------------------------------------------
// usage:
//   write key words, nonce, iv and counter start through cfg_we/cfg_index/
//   cfg_wdata while the block is idle; a counter start write drops any held
//   keystream. one request on the in_ channel is a byte plus a last flag; one
//   result byte comes back on the out_ channel for every request.
// sequencing:
//   a byte that finds keystream held goes from the idle state through the
//   emit state into the output register. a byte that needs a fresh keystream
//   block takes one load plus fourteen passes through the single iterated
//   round unit, with the key schedule running beside it, then the hand-off.
//   a new request is accepted only in the idle state, after the previous
//   byte has been handed to the output register.
// reset:
//   synchronous, active low; control, key, nonce and iv registers clear,
//   counter goes to one and keystream is empty; round unit regs do not reset.
// stall:
//   a stalled result holds in the output register; the next request is still
//   accepted and waits for the output register to free before it is shown.
// ----------------------------------------------------------------------------
module aes256_ctr_keystream_xor
  import aesctr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0]    cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_data_in,
  input  logic                   in_last_in_call,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_data_out
);

  aesctr_cmd_t cmd;
  aesctr_sts_t sts;

  // sequencer
  aesctr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // cipher and keystream datapath
  aesctr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data_in),
    .in_last   (in_last_in_call),
    .out_data  (out_data_out),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
